### src/cdc_pkg.sv
// Shared types and constants for the Collatz delay counter.
`timescale 1ns / 1ps
package cdc_pkg;

   localparam int unsigned VALUE_W = 128;
   localparam int unsigned COUNT_W = 20;

   // Register indexes
   localparam logic CSR_RECORD_THRESHOLD = 1'b0;
   localparam logic CSR_STEP_LIMIT       = 1'b1;

   localparam logic [COUNT_W-1:0] RECORD_THRESHOLD_RESET = 20'd762;
   localparam logic [COUNT_W-1:0] STEP_LIMIT_RESET       = 20'd1000000;

   // Largest n>>1 for which 3*(n>>1)+2 still fits in 128 bits
   localparam logic [VALUE_W-1:0] OVF_LIMIT =
      {64'h5555_5555_5555_5555, 64'h5555_5555_5555_5554};

   typedef enum logic [1:0] {
      ST_ONE      = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_LIMIT    = 2'd2,
      ST_ZERO     = 2'd3
   } cdc_status_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_RUN,
      ENG_DONE
   } cdc_eng_type;

   typedef struct packed {
      logic [63:0] start_high;
      logic [63:0] start_low;
   } cdc_req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] steps;
      cdc_status_type     status;
      logic               new_record;
   } cdc_rsp_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               is_zero;
   } cdc_job_type;

   typedef struct packed {
      logic [COUNT_W-1:0] record_threshold;
      logic [COUNT_W-1:0] step_limit;
   } cdc_cfg_type;

endpackage

### src/cdc_front.sv
// Front end: takes requests, flags zero starts and queues them for the engine.
`timescale 1ns / 1ps
module cdc_front #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  cdc_pkg::cdc_req_type req_data,
   output logic                 job_valid,
   input  logic                 job_pop,
   output cdc_pkg::cdc_job_type job_data
);
   import cdc_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   cdc_job_type        ent_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               pop;
   cdc_job_type        new_job;

   assign req_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign job_valid = (count_ff != '0);
   assign pop       = job_pop && job_valid;
   assign job_data  = ent_ff[rd_ptr_ff];

   always_comb begin
      new_job.value   = {req_data.start_high, req_data.start_low};
      new_job.is_zero = (req_data.start_high == 64'd0) && (req_data.start_low == 64'd0);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= new_job;
      end
   end

endmodule

### src/cdc_back.sv
// Back end: walks the shortcut map one step a cycle and holds the response.
`timescale 1ns / 1ps
module cdc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  cdc_pkg::cdc_cfg_type cfg,
   input  logic                 job_valid,
   output logic                 job_pop,
   input  cdc_pkg::cdc_job_type job_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cdc_pkg::cdc_rsp_type rsp_data
);
   import cdc_pkg::*;

   cdc_eng_type          state_ff, state_in;
   logic [VALUE_W-1:0]   val_ff, val_in;
   logic [COUNT_W-1:0]   cnt_ff, cnt_in;
   cdc_status_type       status_ff, status_in;
   logic                 out_valid_ff, out_valid_in;
   cdc_rsp_type          out_data_ff, out_data_in;

   logic [VALUE_W-1:0]   half;
   logic [VALUE_W-1:0]   tripled;
   logic                 is_one;
   logic                 ovf;
   logic                 out_free;

   assign half     = val_ff >> 1;
   assign tripled  = half + {half[VALUE_W-2:0], 1'b0} + VALUE_W'(2);
   assign is_one   = (val_ff == VALUE_W'(1));
   assign ovf      = (half > OVF_LIMIT);
   assign out_free = !out_valid_ff || !rsp_stall;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      state_in     = state_ff;
      val_in       = val_ff;
      cnt_in       = cnt_ff;
      status_in    = status_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_data_in  = out_data_ff;
      job_pop      = 1'b0;
      unique case (state_ff)
         ENG_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               val_in  = job_data.value;
               cnt_in  = '0;
               if (job_data.is_zero) begin
                  status_in = ST_ZERO;
                  state_in  = ENG_DONE;
               end else begin
                  state_in  = ENG_RUN;
               end
            end
         end
         ENG_RUN: begin
            priority if (is_one) begin
               status_in = ST_ONE;
               state_in  = ENG_DONE;
            end else if (cnt_ff >= cfg.step_limit) begin
               status_in = ST_LIMIT;
               state_in  = ENG_DONE;
            end else if (val_ff[0] && ovf) begin
               status_in = ST_OVERFLOW;
               state_in  = ENG_DONE;
            end else begin
               val_in = val_ff[0] ? tripled : half;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ENG_DONE: begin
            if (out_free) begin
               out_valid_in           = 1'b1;
               out_data_in.status     = status_ff;
               out_data_in.steps      = (status_ff == ST_ONE) ? cnt_ff : '0;
               out_data_in.new_record = (status_ff == ST_ONE) &&
                                        (cnt_ff > cfg.record_threshold);
               state_in               = ENG_IDLE;
            end
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ENG_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      cnt_ff      <= cnt_in;
      status_ff   <= status_in;
      out_data_ff <= out_data_in;
   end

endmodule

### src/collatz_delay_counter_core.sv
// Top level of the Collatz delay counter: registers, front end and step engine.
`timescale 1ns / 1ps
// Each request (a 128-bit start value) gives one response: the shortcut-map step
// count to reach one, a status and a record flag. The engine does one map step a
// cycle until the request reaches one, overflows or hits the step limit; a zero
// start skips the walk. A QUEUE_DEPTH-entry queue in front of the engine and the
// response register let requests and responses move while the engine is busy.
// Write the registers only while no request is outstanding.
module collatz_delay_counter_core #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  cdc_pkg::cdc_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cdc_pkg::cdc_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_index,
   input  logic [19:0]          csr_wdata
);
   import cdc_pkg::*;

   cdc_cfg_type cfg_ff, cfg_in;
   logic        job_valid;
   logic        job_pop;
   cdc_job_type job_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RECORD_THRESHOLD: cfg_in.record_threshold = csr_wdata;
            CSR_STEP_LIMIT:       cfg_in.step_limit       = csr_wdata;
            default:              cfg_in                  = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.record_threshold <= RECORD_THRESHOLD_RESET;
         cfg_ff.step_limit       <= STEP_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cdc_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job_pop   (job_pop),
      .job_data  (job_data)
   );

   cdc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (job_valid),
      .job_pop   (job_pop),
      .job_data  (job_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### src/cdc_checker.sv
// Port-level checks for the Collatz delay counter, bound to the top level.
`timescale 1ns / 1ps
module cdc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input cdc_pkg::cdc_rsp_type rsp_data
);
   import cdc_pkg::*;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_fail_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_ONE) |->
         (rsp_data.steps == '0) && !rsp_data.new_record)
      else $error("failed request carries count or record");

   a_zero_no_record: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.steps == '0) |-> !rsp_data.new_record)
      else $error("record flagged with zero steps");

endmodule

bind collatz_delay_counter_core cdc_checker u_cdc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
